// ----- rtl/lbs_pkg.sv -----
// Lexeme boundary scanner package: lexeme classes, scan modes, record types
// and byte classification functions. No dependencies.
package lbs_pkg;

  // Width of every position/length field in a result record
  localparam int FieldW = 21;
  // Most records one byte can produce
  localparam int RecN   = 3;

  // Bytes the scanner looks at by value
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    CLS_SPACE    = 3'd0,
    CLS_QUOTE    = 3'd1,
    CLS_OPERAND  = 3'd2,
    CLS_OPERATOR = 3'd3,
    CLS_DELIM    = 3'd4,
    CLS_ILLEGAL  = 3'd5,
    CLS_END      = 3'd6
  } lbs_class_e;

  typedef enum logic [2:0] {
    MODE_BOUND = 3'd0,
    MODE_SPACE = 3'd1,
    MODE_QUOTE = 3'd2,
    MODE_OPND  = 3'd3,
    MODE_OPER  = 3'd4,
    MODE_LINE  = 3'd5,
    MODE_BLOCK = 3'd6
  } lbs_mode_e;

  // One result item
  typedef struct packed {
    lbs_class_e        cls;
    logic [7:0]        first;
    logic [FieldW-1:0] loc;
    logic [FieldW-1:0] len;
    logic [FieldW-1:0] line;
    logic [FieldW-1:0] col;
    logic              last;
  } lbs_rec_t;

  // All records caused by one input item, in order; count is 1..RecN if pushed
  typedef struct packed {
    logic [1:0]            count;
    lbs_rec_t [RecN-1:0]   recs;
  } lbs_bundle_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } lbs_qstat_t;

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  endfunction

  function automatic logic is_quote(input logic [7:0] b);
    is_quote = (b == CH_DQUOTE) || (b == CH_SQUOTE);
  endfunction

  // NUL and " \n,;`()[]{}"
  function automatic logic is_delim(input logic [7:0] b);
    case (b)
      8'h00, 8'h20, 8'h0A, 8'h2C, 8'h3B, 8'h60,
      8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D: is_delim = 1'b1;
      default:                                  is_delim = 1'b0;
    endcase
  endfunction

  // letters, digits, single quote, underscore
  function automatic logic is_operand(input logic [7:0] b);
    is_operand = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                 (b >= 8'h61 && b <= 8'h7A) || (b == CH_SQUOTE) || (b == 8'h5F);
  endfunction

  // "{};@$"
  function automatic logic is_excluded(input logic [7:0] b);
    case (b)
      8'h7B, 8'h7D, 8'h3B, 8'h40, 8'h24: is_excluded = 1'b1;
      default:                           is_excluded = 1'b0;
    endcase
  endfunction

  function automatic logic is_operator(input logic [7:0] b);
    is_operator = (b != CH_NUL) && !b[7] && !is_delim(b) && !is_operand(b) &&
                  !is_quote(b) && !is_excluded(b);
  endfunction

  function automatic lbs_class_e mode_class(input lbs_mode_e m);
    case (m)
      MODE_SPACE: mode_class = CLS_SPACE;
      MODE_QUOTE: mode_class = CLS_QUOTE;
      MODE_OPND:  mode_class = CLS_OPERAND;
      default:    mode_class = CLS_OPERATOR;
    endcase
  endfunction

endpackage

// ----- rtl/lexeme_boundary_scanner.sv -----
// Lexeme boundary scanner top level: front end, bundle queue, output stage.
// Depends on lbs_pkg, lbs_front, lbs_queue, lbs_back.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------------------
//   in      | in_valid_i / in_ready_o | text_byte_i, end_of_text_i
//   out     | out_valid_o/out_ready_i | lexeme_class_o, first_byte_o, ...,
//           |                         | start_column_o, last_result_o
//
// A byte is taken every cycle while the two-entry queue has room. Each byte
// yields zero to three lexemes, handed out one item per cycle by the output
// stage while out_ready_i is high, so the sustained rate is one byte per
// cycle when at most one lexeme per byte is produced, and output-limited
// otherwise. Reset clears the scan state and empties the queue. A stalled
// output fills the queue and then drops in_ready_o; the two sides otherwise
// stall independently.
module lexeme_boundary_scanner #(
  parameter longint unsigned MaxTextBytes = 64'd1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  lexeme_class_o,
  output logic [7:0]  first_byte_o,
  output logic [20:0] lexeme_location_o,
  output logic [20:0] lexeme_length_o,
  output logic [20:0] start_line_o,
  output logic [20:0] start_column_o,
  output logic        last_result_o
);

  lbs_pkg::lbs_bundle_t bundle, head;
  lbs_pkg::lbs_qstat_t  qstat;
  logic                 push, pop;

  lbs_front #(
    .MaxTextBytes(MaxTextBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .q_stat_i     (qstat),
    .push_o       (push),
    .bundle_o     (bundle)
  );

  lbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .bundle_i(bundle),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  lbs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .stat_i           (qstat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .lexeme_class_o   (lexeme_class_o),
    .first_byte_o     (first_byte_o),
    .lexeme_location_o(lexeme_location_o),
    .lexeme_length_o  (lexeme_length_o),
    .start_line_o     (start_line_o),
    .start_column_o   (start_column_o),
    .last_result_o    (last_result_o)
  );

  // queue is never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("bundle pushed into a full queue");

  // fill count stays consistent
  a_qstat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  // only the end lexeme carries the last flag
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_result_o == (lexeme_class_o == 3'(lbs_pkg::CLS_END))))
    else $error("last flag and end class disagree");

  // an accepted final byte always leaves work for the output stage
  a_eot_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_text_i) |=> !qstat.empty)
    else $error("end of text produced no queued lexemes");

endmodule

// ----- rtl/lbs_front.sv -----
// Front end: accepts text bytes, runs the scan state machine and position
// counters, and pushes the records of each byte as one bundle.
// Depends on lbs_pkg.
module lbs_front #(
  parameter longint unsigned MaxTextBytes = 64'd1048576
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  input  lbs_pkg::lbs_qstat_t q_stat_i,
  output logic                push_o,
  output lbs_pkg::lbs_bundle_t bundle_o
);

  localparam int              CntW   = $clog2(MaxTextBytes + 64'd1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxTextBytes);
  localparam logic [CntW-1:0] OneCnt = CntW'(1);

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v >= MaxCnt) ? MaxCnt : v + OneCnt;
  endfunction

  lbs_pkg::lbs_mode_e mode_q, mode_s, mode_d, cur;
  logic slash_q, slash_s, slash_d;
  logic star_q, star_s, star_d;
  logic esc_q, esc_s, esc_d;
  logic qkind_q, qkind_s, qkind_d;
  logic [CntW-1:0] start_q, start_s, start_d;
  logic [CntW-1:0] off_q, off_s, off_d;
  logic [CntW-1:0] line_q, line_s, line_d;
  logic [CntW-1:0] col_q, col_s, col_d;
  logic [CntW-1:0] sline_q, sline_s, sline_d;
  logic [CntW-1:0] scol_q, scol_s, scol_d;
  logic [CntW-1:0] len_q, len_s, len_d;
  logic [7:0]      first_q, first_s, first_d;

  logic               held, takes, do_start;
  logic               emit_a, emit_b, emit_c;
  lbs_pkg::lbs_class_e a_cls, b_cls, c_cls;
  logic [CntW-1:0]    a_len;
  logic [7:0]         b, qc;
  logic               accept;
  logic [1:0]         n;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = text_byte_i;
  assign qc         = qkind_q ? lbs_pkg::CH_SQUOTE : lbs_pkg::CH_DQUOTE;

  // Next state: one scan step, then end-of-text return to reset values
  always_comb begin
    mode_s   = mode_q;
    slash_s  = slash_q;
    star_s   = star_q;
    esc_s    = esc_q;
    qkind_s  = qkind_q;
    start_s  = start_q;
    sline_s  = sline_q;
    scol_s   = scol_q;
    len_s    = len_q;
    first_s  = first_q;
    cur      = mode_q;
    held     = 1'b0;
    do_start = 1'b0;
    emit_a   = 1'b0;
    a_cls    = lbs_pkg::CLS_OPERATOR;
    a_len    = len_q;
    emit_b   = 1'b0;
    b_cls    = lbs_pkg::CLS_DELIM;

    // held slash at a boundary: comment opener or start of operator run
    if (mode_q == lbs_pkg::MODE_BOUND && slash_q) begin
      slash_s = 1'b0;
      if (b == lbs_pkg::CH_SLASH) begin
        mode_s = lbs_pkg::MODE_LINE;
        held   = 1'b1;
      end else if (b == lbs_pkg::CH_STAR) begin
        mode_s = lbs_pkg::MODE_BLOCK;
        star_s = 1'b1;
        held   = 1'b1;
      end else begin
        cur    = lbs_pkg::MODE_OPER;
        mode_s = lbs_pkg::MODE_OPER;
      end
    end

    // run membership for the current mode
    case (cur)
      lbs_pkg::MODE_SPACE: takes = lbs_pkg::is_space(b);
      lbs_pkg::MODE_OPND:  takes = lbs_pkg::is_operand(b);
      default:             takes = lbs_pkg::is_operator(b);
    endcase

    if (!held) begin
      case (cur)
        lbs_pkg::MODE_BOUND: do_start = 1'b1;
        lbs_pkg::MODE_SPACE, lbs_pkg::MODE_OPND, lbs_pkg::MODE_OPER: begin
          if (takes) begin
            len_s = sat_inc(len_q);
          end else begin
            emit_a   = 1'b1;
            a_cls    = lbs_pkg::mode_class(cur);
            do_start = 1'b1;
          end
        end
        lbs_pkg::MODE_QUOTE: begin
          if (esc_q) begin
            esc_s = 1'b0;
            len_s = sat_inc(len_q);
          end else if (b == lbs_pkg::CH_NL) begin
            // unterminated quote stops before the newline
            emit_a   = 1'b1;
            a_cls    = lbs_pkg::CLS_QUOTE;
            do_start = 1'b1;
          end else begin
            len_s = sat_inc(len_q);
            a_len = sat_inc(len_q);
            if (b == lbs_pkg::CH_BSLASH) begin
              esc_s = 1'b1;
            end else if (b == qc) begin
              emit_a = 1'b1;
              a_cls  = lbs_pkg::CLS_QUOTE;
              mode_s = lbs_pkg::MODE_BOUND;
            end
          end
        end
        lbs_pkg::MODE_LINE: begin
          if (b == lbs_pkg::CH_NL) do_start = 1'b1;
        end
        lbs_pkg::MODE_BLOCK: begin
          if (star_q && b == lbs_pkg::CH_SLASH) begin
            mode_s = lbs_pkg::MODE_BOUND;
            star_s = 1'b0;
          end else begin
            star_s = (b == lbs_pkg::CH_STAR);
          end
        end
        default: do_start = 1'b1;
      endcase

      // new lexeme starting with this byte
      if (do_start) begin
        start_s = off_q;
        sline_s = line_q;
        scol_s  = col_q;
        first_s = b;
        len_s   = OneCnt;
        if (b == lbs_pkg::CH_SLASH) begin
          slash_s = 1'b1;
          mode_s  = lbs_pkg::MODE_BOUND;
        end else if (lbs_pkg::is_space(b)) begin
          mode_s = lbs_pkg::MODE_SPACE;
        end else if (lbs_pkg::is_quote(b)) begin
          mode_s  = lbs_pkg::MODE_QUOTE;
          qkind_s = (b == lbs_pkg::CH_SQUOTE);
          esc_s   = 1'b0;
        end else if (lbs_pkg::is_operand(b)) begin
          mode_s = lbs_pkg::MODE_OPND;
        end else if (lbs_pkg::is_operator(b)) begin
          mode_s = lbs_pkg::MODE_OPER;
        end else begin
          emit_b = 1'b1;
          b_cls  = lbs_pkg::is_delim(b) ? lbs_pkg::CLS_DELIM : lbs_pkg::CLS_ILLEGAL;
          mode_s = lbs_pkg::MODE_BOUND;
        end
      end
    end

    // position counters
    off_s = sat_inc(off_q);
    if (b == lbs_pkg::CH_NL) begin
      line_s = sat_inc(line_q);
      col_s  = OneCnt;
    end else begin
      line_s = line_q;
      col_s  = sat_inc(col_q);
    end

    // open lexeme flushed at end of text
    emit_c = end_of_text_i &&
             ((mode_s == lbs_pkg::MODE_BOUND && slash_s) ||
              mode_s == lbs_pkg::MODE_SPACE || mode_s == lbs_pkg::MODE_QUOTE ||
              mode_s == lbs_pkg::MODE_OPND  || mode_s == lbs_pkg::MODE_OPER);
    c_cls  = (mode_s == lbs_pkg::MODE_BOUND) ? lbs_pkg::CLS_OPERATOR
                                             : lbs_pkg::mode_class(mode_s);

    if (end_of_text_i) begin
      mode_d  = lbs_pkg::MODE_BOUND;
      slash_d = 1'b0;
      star_d  = 1'b0;
      esc_d   = 1'b0;
      qkind_d = 1'b0;
      start_d = OneCnt;
      off_d   = OneCnt;
      line_d  = OneCnt;
      col_d   = OneCnt;
      sline_d = OneCnt;
      scol_d  = OneCnt;
      len_d   = '0;
      first_d = '0;
    end else begin
      mode_d  = mode_s;
      slash_d = slash_s;
      star_d  = star_s;
      esc_d   = esc_s;
      qkind_d = qkind_s;
      start_d = start_s;
      off_d   = off_s;
      line_d  = line_s;
      col_d   = col_s;
      sline_d = sline_s;
      scol_d  = scol_s;
      len_d   = len_s;
      first_d = first_s;
    end
  end

  // Outputs: pack the records of this byte in order
  always_comb begin
    lbs_pkg::lbs_rec_t rec_a, rec_b, rec_c, rec_d;

    rec_a.cls   = a_cls;
    rec_a.first = first_q;
    rec_a.loc   = lbs_pkg::FieldW'(start_q);
    rec_a.len   = lbs_pkg::FieldW'(a_len);
    rec_a.line  = lbs_pkg::FieldW'(sline_q);
    rec_a.col   = lbs_pkg::FieldW'(scol_q);
    rec_a.last  = 1'b0;

    rec_b.cls   = b_cls;
    rec_b.first = b;
    rec_b.loc   = lbs_pkg::FieldW'(off_q);
    rec_b.len   = lbs_pkg::FieldW'(OneCnt);
    rec_b.line  = lbs_pkg::FieldW'(line_q);
    rec_b.col   = lbs_pkg::FieldW'(col_q);
    rec_b.last  = 1'b0;

    rec_c.cls   = c_cls;
    rec_c.first = first_s;
    rec_c.loc   = lbs_pkg::FieldW'(start_s);
    rec_c.len   = lbs_pkg::FieldW'(len_s);
    rec_c.line  = lbs_pkg::FieldW'(sline_s);
    rec_c.col   = lbs_pkg::FieldW'(scol_s);
    rec_c.last  = 1'b0;

    rec_d.cls   = lbs_pkg::CLS_END;
    rec_d.first = 8'h00;
    rec_d.loc   = lbs_pkg::FieldW'(off_s);
    rec_d.len   = lbs_pkg::FieldW'(OneCnt);
    rec_d.line  = lbs_pkg::FieldW'(line_s);
    rec_d.col   = lbs_pkg::FieldW'(col_s);
    rec_d.last  = 1'b1;

    bundle_o = '0;
    n        = 2'd0;
    if (emit_a && n != 2'd3) begin
      bundle_o.recs[n] = rec_a;
      n = n + 2'd1;
    end
    if (emit_b && n != 2'd3) begin
      bundle_o.recs[n] = rec_b;
      n = n + 2'd1;
    end
    if (emit_c && n != 2'd3) begin
      bundle_o.recs[n] = rec_c;
      n = n + 2'd1;
    end
    if (end_of_text_i && n != 2'd3) begin
      bundle_o.recs[n] = rec_d;
      n = n + 2'd1;
    end
    bundle_o.count = n;
    push_o         = accept && (n != 2'd0);
  end

  // State registers, updated per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lbs_pkg::MODE_BOUND;
      slash_q <= 1'b0;
      star_q  <= 1'b0;
      esc_q   <= 1'b0;
      qkind_q <= 1'b0;
      start_q <= OneCnt;
      off_q   <= OneCnt;
      line_q  <= OneCnt;
      col_q   <= OneCnt;
      sline_q <= OneCnt;
      scol_q  <= OneCnt;
      len_q   <= '0;
      first_q <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
      star_q  <= star_d;
      esc_q   <= esc_d;
      qkind_q <= qkind_d;
      start_q <= start_d;
      off_q   <= off_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      len_q   <= len_d;
      first_q <= first_d;
    end
  end

endmodule

// ----- rtl/lbs_queue.sv -----
// Two-entry bundle queue between the scan front end and the output stage.
// Depends on lbs_pkg.
module lbs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lbs_pkg::lbs_bundle_t bundle_i,
  input  logic                 pop_i,
  output lbs_pkg::lbs_bundle_t head_o,
  output lbs_pkg::lbs_qstat_t  stat_o
);

  lbs_pkg::lbs_bundle_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign cnt_d        = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_q ^ push_i;
      rd_q  <= rd_q ^ pop_i;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/lbs_back.sv -----
// Output stage: hands out head bundle records one item per cycle while
// out_ready_i is high; pops it after its last record. Depends on lbs_pkg.
module lbs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbs_pkg::lbs_bundle_t head_i,
  input  lbs_pkg::lbs_qstat_t  stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           lexeme_class_o,
  output logic [7:0]           first_byte_o,
  output logic [20:0]          lexeme_location_o,
  output logic [20:0]          lexeme_length_o,
  output logic [20:0]          start_line_o,
  output logic [20:0]          start_column_o,
  output logic                 last_result_o
);

  lbs_pkg::lbs_rec_t rec;
  logic [1:0] idx_q, idx_d;
  logic       fire, last_of;

  assign rec         = head_i.recs[idx_q];
  assign out_valid_o = !stat_i.empty;
  assign fire        = out_valid_o && out_ready_i;
  assign last_of     = (idx_q == head_i.count - 2'd1);
  assign pop_o       = fire && last_of;

  assign lexeme_class_o    = rec.cls;
  assign first_byte_o      = rec.first;
  assign lexeme_location_o = rec.loc;
  assign lexeme_length_o   = rec.len;
  assign start_line_o      = rec.line;
  assign start_column_o    = rec.col;
  assign last_result_o     = rec.last;

  // record index within the head bundle
  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = last_of ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ----- test/lexeme_boundary_scanner_test.sv -----
// Self-checking bench for lexeme_boundary_scanner: byte streams in, lexeme items out,
// each compared against a behavioural scanner kept alongside the DUT.
// Depends on lbs_pkg and rtl/lexeme_boundary_scanner.sv.
module lexeme_boundary_scanner_test;

  localparam logic [20:0] TEXT_MAX = 21'd1048576;
  localparam int          DRAIN_CYCLES = 16;

  // Kinds of source fragment the random text builder strings together
  typedef enum int {
    PC_WORD, PC_BLANK, PC_DQ, PC_SQ, PC_LINECMT, PC_BLOCKCMT,
    PC_OPS, PC_DELIM, PC_ILLEGAL, PC_NEWLINE, PC_NOISE
  } piece_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = 8'd0;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  lexeme_class_o;
  logic [7:0]  first_byte_o;
  logic [20:0] lexeme_location_o;
  logic [20:0] lexeme_length_o;
  logic [20:0] start_line_o;
  logic [20:0] start_column_o;
  logic        last_result_o;

  lexeme_boundary_scanner dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .text_byte_i, .end_of_text_i,
    .out_valid_o, .out_ready_i, .lexeme_class_o, .first_byte_o, .lexeme_location_o,
    .lexeme_length_o, .start_line_o, .start_column_o, .last_result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("lexeme_boundary_scanner_test: errors");
    $finish;
  end

  // Bench bookkeeping
  lbs_pkg::lbs_rec_t lexeme_q[$];
  logic [7:0]  text_q[$];
  int          errors = 0;
  int          lexemes_seen = 0;
  int          bytes_sent = 0;
  int          texts_sent = 0;
  logic        calm = 1'b0;
  int          ready_left = 0;

  string word_chars  = "abzAZ09_'x7Q";
  string ops_chars   = "+-*<>=!&|^~%?.:#\\/\t\r";
  string delim_chars = " \n,;()[]{}";
  string blank_chars = " \t\r";

  // Scanner shadow state
  lbs_pkg::lbs_mode_e mode_q;
  logic        slash_q, star_q, esc_q, squote_q;
  logic [20:0] start_loc, offs, line_n, col_n, start_ln, start_col, lex_len;
  logic [7:0]  lex_first;

  // ---------------------------------------------------------------------------
  // Byte classes
  function automatic logic blank(input logic [7:0] b);
    return b == lbs_pkg::CH_SPACE || b == lbs_pkg::CH_TAB || b == lbs_pkg::CH_CR;
  endfunction

  function automatic logic quote_ch(input logic [7:0] b);
    return b == lbs_pkg::CH_DQUOTE || b == lbs_pkg::CH_SQUOTE;
  endfunction

  function automatic logic delim(input logic [7:0] b);
    case (b)
      lbs_pkg::CH_NUL, lbs_pkg::CH_SPACE, lbs_pkg::CH_NL: return 1'b1;
      ",", ";", "(", ")", "[", "]", "{", "}":             return 1'b1;
      8'h60:   return 1'b1; // backtick
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic word(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == lbs_pkg::CH_SQUOTE || b == "_";
  endfunction

  function automatic logic oper(input logic [7:0] b);
    logic barred;
    barred = b == "{" || b == "}" || b == ";" || b == "@" || b == "$";
    return b >= 8'd1 && b <= 8'd127 && !delim(b) && !word(b) && !quote_ch(b) && !barred;
  endfunction

  function automatic logic run_takes(input lbs_pkg::lbs_mode_e m, input logic [7:0] b);
    case (m)
      lbs_pkg::MODE_SPACE: return blank(b);
      lbs_pkg::MODE_OPND:  return word(b);
      default:             return oper(b);
    endcase
  endfunction

  function automatic lbs_pkg::lbs_class_e run_class(input lbs_pkg::lbs_mode_e m);
    case (m)
      lbs_pkg::MODE_SPACE: return lbs_pkg::CLS_SPACE;
      lbs_pkg::MODE_QUOTE: return lbs_pkg::CLS_QUOTE;
      lbs_pkg::MODE_OPND:  return lbs_pkg::CLS_OPERAND;
      default:             return lbs_pkg::CLS_OPERATOR;
    endcase
  endfunction

  function automatic logic [20:0] bump(input logic [20:0] v);
    return (v >= TEXT_MAX) ? TEXT_MAX : v + 21'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Shadow scanner
  task automatic restart_text();
    mode_q    = lbs_pkg::MODE_BOUND;
    slash_q   = 1'b0;
    star_q    = 1'b0;
    esc_q     = 1'b0;
    squote_q  = 1'b0;
    start_loc = 21'd1;
    offs      = 21'd1;
    line_n    = 21'd1;
    col_n     = 21'd1;
    start_ln  = 21'd1;
    start_col = 21'd1;
    lex_len   = 21'd0;
    lex_first = 8'd0;
  endtask

  task automatic emit_lexeme(input lbs_pkg::lbs_class_e cls);
    lbs_pkg::lbs_rec_t r;
    r.cls   = cls;
    r.first = lex_first;
    r.loc   = start_loc;
    r.len   = lex_len;
    r.line  = start_ln;
    r.col   = start_col;
    r.last  = 1'b0;
    lexeme_q.push_back(r);
  endtask

  // New lexeme (or a held slash) starting with b
  task automatic open_lexeme(input logic [7:0] b);
    start_loc = offs;
    start_ln  = line_n;
    start_col = col_n;
    lex_first = b;
    lex_len   = 21'd1;
    if (b == lbs_pkg::CH_SLASH) begin
      slash_q = 1'b1;
      mode_q  = lbs_pkg::MODE_BOUND;
    end else if (blank(b)) begin
      mode_q = lbs_pkg::MODE_SPACE;
    end else if (quote_ch(b)) begin
      mode_q   = lbs_pkg::MODE_QUOTE;
      squote_q = (b == lbs_pkg::CH_SQUOTE);
      esc_q    = 1'b0;
    end else if (word(b)) begin
      mode_q = lbs_pkg::MODE_OPND;
    end else if (oper(b)) begin
      mode_q = lbs_pkg::MODE_OPER;
    end else begin
      if (delim(b)) emit_lexeme(lbs_pkg::CLS_DELIM);
      else emit_lexeme(lbs_pkg::CLS_ILLEGAL);
      mode_q = lbs_pkg::MODE_BOUND;
    end
  endtask

  // Works out the lexemes that one accepted byte completes
  task automatic scan_byte(input logic [7:0] b, input logic eot);
    logic              skip;
    logic [7:0]        closer;
    lbs_pkg::lbs_rec_t fin;
    skip = 1'b0;
    // a held slash decides between comment and operator
    if (mode_q == lbs_pkg::MODE_BOUND && slash_q) begin
      slash_q = 1'b0;
      if (b == lbs_pkg::CH_SLASH) begin
        mode_q = lbs_pkg::MODE_LINE;
        skip   = 1'b1;
      end else if (b == lbs_pkg::CH_STAR) begin
        mode_q = lbs_pkg::MODE_BLOCK;
        star_q = 1'b1;
        skip   = 1'b1;
      end else begin
        mode_q = lbs_pkg::MODE_OPER;
      end
    end
    if (!skip) begin
      case (mode_q)
        lbs_pkg::MODE_BOUND: open_lexeme(b);
        lbs_pkg::MODE_SPACE, lbs_pkg::MODE_OPND, lbs_pkg::MODE_OPER: begin
          if (run_takes(mode_q, b)) begin
            lex_len = bump(lex_len);
          end else begin
            emit_lexeme(run_class(mode_q));
            mode_q = lbs_pkg::MODE_BOUND;
            open_lexeme(b);
          end
        end
        lbs_pkg::MODE_QUOTE: begin
          closer = squote_q ? lbs_pkg::CH_SQUOTE : lbs_pkg::CH_DQUOTE;
          if (esc_q) begin
            esc_q   = 1'b0;
            lex_len = bump(lex_len);
          end else if (b == lbs_pkg::CH_NL) begin
            // unterminated: quote ends before the newline
            emit_lexeme(lbs_pkg::CLS_QUOTE);
            mode_q = lbs_pkg::MODE_BOUND;
            open_lexeme(b);
          end else begin
            lex_len = bump(lex_len);
            if (b == lbs_pkg::CH_BSLASH) begin
              esc_q = 1'b1;
            end else if (b == closer) begin
              emit_lexeme(lbs_pkg::CLS_QUOTE);
              mode_q = lbs_pkg::MODE_BOUND;
            end
          end
        end
        lbs_pkg::MODE_LINE: begin
          if (b == lbs_pkg::CH_NL) begin
            mode_q = lbs_pkg::MODE_BOUND;
            open_lexeme(b);
          end
        end
        default: begin
          if (star_q && b == lbs_pkg::CH_SLASH) begin
            mode_q = lbs_pkg::MODE_BOUND;
            star_q = 1'b0;
          end else begin
            star_q = (b == lbs_pkg::CH_STAR);
          end
        end
      endcase
    end
    // position after this byte
    offs = bump(offs);
    if (b == lbs_pkg::CH_NL) begin
      line_n = bump(line_n);
      col_n  = 21'd1;
    end else begin
      col_n = bump(col_n);
    end
    if (eot) begin
      if (mode_q == lbs_pkg::MODE_BOUND && slash_q) emit_lexeme(lbs_pkg::CLS_OPERATOR);
      else if (mode_q inside {lbs_pkg::MODE_SPACE, lbs_pkg::MODE_QUOTE,
                              lbs_pkg::MODE_OPND, lbs_pkg::MODE_OPER})
        emit_lexeme(run_class(mode_q));
      fin.cls   = lbs_pkg::CLS_END;
      fin.first = 8'd0;
      fin.loc   = offs;
      fin.len   = 21'd1;
      fin.line  = line_n;
      fin.col   = col_n;
      fin.last  = 1'b1;
      lexeme_q.push_back(fin);
      restart_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output side back-pressure
  always @(posedge clk_i) begin : ready_gen
    int hold;
    if (calm) begin
      out_ready_i <= 1'b1;
      ready_left  <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      hold = pick_gap();
      if (hold == 0) begin
        out_ready_i <= 1'b1;
        ready_left  <= $urandom_range(0, 6);
      end else begin
        out_ready_i <= 1'b0;
        ready_left  <= hold - 1;
      end
    end
  end

  task automatic check_field(input string what, input logic [20:0] want,
                             input logic [20:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Every accepted result item against the oldest expectation
  always @(posedge clk_i) begin : check_out
    lbs_pkg::lbs_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lexeme_q.size() == 0) begin
        errors++;
        $display("%0t: expected no lexeme, got class %0d first %0d at %0d len %0d",
                 $time, lexeme_class_o, first_byte_o, lexeme_location_o, lexeme_length_o);
      end else begin
        want = lexeme_q.pop_front();
        check_field("class", 21'(want.cls), 21'(lexeme_class_o));
        check_field("first_byte", 21'(want.first), 21'(first_byte_o));
        check_field("location", want.loc, lexeme_location_o);
        check_field("length", want.len, lexeme_length_o);
        check_field("start_line", want.line, start_line_o);
        check_field("start_column", want.col, start_column_o);
        check_field("last", 21'(want.last), 21'(last_result_o));
        lexemes_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sending
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    scan_byte(b, eot);
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Sends the built text with the end mark on its last byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (lexeme_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_quoted(input logic [7:0] q);
    int n;
    text_q.push_back(q);
    n = $urandom_range(0, 6);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        text_q.push_back(lbs_pkg::CH_BSLASH);
        text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        text_q.push_back(8'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(0, 4) != 0) text_q.push_back(q);
  endtask

  // Appends one random source fragment
  task automatic add_piece();
    piece_e kind;
    int     n;
    string  bc;
    bc   = "ab*/ \n";
    kind = piece_e'($urandom_range(0, PC_NOISE));
    n    = $urandom_range(1, 4);
    case (kind)
      PC_WORD:
        repeat (n + $urandom_range(0, 2))
          text_q.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      PC_BLANK: repeat (n) text_q.push_back(blank_chars[$urandom_range(0, 2)]);
      PC_DQ: add_quoted(lbs_pkg::CH_DQUOTE);
      PC_SQ: add_quoted(lbs_pkg::CH_SQUOTE);
      PC_LINECMT: begin
        add_str("//");
        repeat (n) text_q.push_back(8'($urandom_range(32, 126)));
        text_q.push_back(lbs_pkg::CH_NL);
      end
      PC_BLOCKCMT: begin
        add_str("/*");
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(lbs_pkg::CH_SLASH);
        end else begin
          repeat (n) text_q.push_back(bc[$urandom_range(0, bc.len() - 1)]);
          add_str("*/");
        end
      end
      PC_OPS: repeat (n) text_q.push_back(ops_chars[$urandom_range(0, ops_chars.len() - 1)]);
      PC_DELIM: begin
        if ($urandom_range(0, 10) == 0) text_q.push_back(8'h60);
        else text_q.push_back(delim_chars[$urandom_range(0, delim_chars.len() - 1)]);
      end
      PC_ILLEGAL: begin
        case ($urandom_range(0, 2))
          0:       text_q.push_back("@");
          1:       text_q.push_back("$");
          default: text_q.push_back(8'($urandom_range(128, 255)));
        endcase
      end
      PC_NEWLINE: text_q.push_back(lbs_pkg::CH_NL);
      default:    text_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  task automatic test_directed();
    // escape over newline, byte zero, high illegal, slash held at end of text
    add_str("a\t\"\\\n\"");
    text_q.push_back(lbs_pkg::CH_NUL);
    text_q.push_back(8'h80);
    text_q.push_back(lbs_pkg::CH_SLASH);
    send_text();
    // block comment closed on its own star, single-quoted literal, line comment,
    // illegal dollar, slash turning into an operator
    add_str("/*/'x'//@\n$/q");
    send_text();
    // quote cut at newline, top illegal byte, operator run taking a tab
    add_str("\"\r\n");
    text_q.push_back(8'hFF);
    add_str("+\t}");
    send_text();
    settle();
  endtask

  task automatic test_wellformed();
    int stop;
    stop = bytes_sent + 50;
    while (bytes_sent < stop) begin
      repeat ($urandom_range(1, 8)) add_piece();
      send_text();
    end
    settle();
  endtask

  // Texts cut off inside a comment, quote, escape or held slash
  task automatic test_open_ends();
    repeat (6) begin
      repeat ($urandom_range(0, 3)) add_piece();
      case ($urandom_range(0, 5))
        0:       add_str("/*ab*");
        1:       add_str("/");
        2:       add_str("\"ab");
        3:       add_str("'a\\");
        4:       add_str("//x");
        default: add_str("/*");
      endcase
      send_text();
    end
    settle();
  endtask

  task automatic test_steady();
    int stop;
    calm = 1'b1;
    stop = bytes_sent + 30;
    while (bytes_sent < stop) begin
      repeat ($urandom_range(2, 6)) add_piece();
      send_text();
    end
    settle();
    calm = 1'b0;
  endtask

  // Arbitrary bytes with the end mark falling anywhere
  task automatic test_noise();
    int stop;
    stop = bytes_sent + 40;
    while (bytes_sent < stop)
      send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
    send_byte(8'($urandom_range(1, 255)), 1'b1);
    texts_sent++;
    settle();
  endtask

  initial begin
    restart_text();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_wellformed();
    test_open_ends();
    test_steady();
    test_noise();
    $display("run covered %0d bytes over %0d texts and %0d lexemes checked,",
             bytes_sent, texts_sent, lexemes_seen);
    $display("with comments, quotes, escapes, illegal bytes and stalls on both sides");
    if (errors == 0) begin
      $display("lexeme_boundary_scanner_test: clean");
    end else begin
      $display("lexeme_boundary_scanner_test: errors");
    end
    $finish;
  end

endmodule

// ----- lexeme_boundary_scanner.f -----
rtl/lbs_pkg.sv
rtl/lbs_front.sv
rtl/lbs_queue.sv
rtl/lbs_back.sv
rtl/lexeme_boundary_scanner.sv
test/lexeme_boundary_scanner_test.sv
